/* hdl/hdsa_pkg.sv */
// ----------------------------------------------------------------------------
// hdsa_pkg
// Shared types and constants of the half-day sensor averager.
// ----------------------------------------------------------------------------
package hdsa_pkg;

    // field widths fixed by the item format
    localparam int DAY_IN_W  = 16;
    localparam int SEC_W     = 17;
    localparam int TEMP_W    = 12;
    localparam int HUM_W     = 10;
    localparam int CFG_IDX_W = 2;

    // default sizing of counts and stored day index
    localparam int COUNT_BITS_DEF = 16;
    localparam int DAY_BITS_DEF   = 16;

    // time-of-day helpers
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_MIN  = 60;

    // window bound reset values
    localparam logic [SEC_W-1:0] FIRST_START_RST  = '0;
    localparam logic [SEC_W-1:0] FIRST_END_RST    =
        SEC_W'(11 * SEC_PER_HOUR + 59 * SEC_PER_MIN);
    localparam logic [SEC_W-1:0] SECOND_START_RST = SEC_W'(12 * SEC_PER_HOUR);
    localparam logic [SEC_W-1:0] SECOND_END_RST   =
        SEC_W'(23 * SEC_PER_HOUR + 59 * SEC_PER_MIN);

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_START,
        REG_FIRST_END,
        REG_SECOND_START,
        REG_SECOND_END
    } t_cfg_reg;

    // division operations of one day close, in issue order
    typedef enum logic [1:0] {
        OP_TEMP_FIRST,
        OP_HUM_FIRST,
        OP_TEMP_SECOND,
        OP_HUM_SECOND
    } t_op;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                     cmd;
        logic [DAY_IN_W-1:0]      day_number;
        logic [SEC_W-1:0]         second_of_day;
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
    } t_in_item;

    typedef struct packed {
        logic [DAY_IN_W-1:0]      record_day;
        logic                     first_present;
        logic signed [TEMP_W-1:0] temp_first_mean;
        logic [HUM_W-1:0]         humid_first_mean;
        logic                     second_present;
        logic signed [TEMP_W-1:0] temp_second_mean;
        logic [HUM_W-1:0]         humid_second_mean;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic div_start;
        logic store_q;
        logic load_out;
        t_op  op;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit_req;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

/* hdl/hdsa_ctrl.sv */
// ----------------------------------------------------------------------------
// hdsa_ctrl
// Sequencer: takes items, runs the four mean divisions of a day close and
// hands the finished record to the output register.
// ----------------------------------------------------------------------------
module hdsa_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  hdsa_pkg::t_dp_status  i_status,
    output hdsa_pkg::t_ctrl_cmd   o_cmd
);
    import hdsa_pkg::*;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    // state and operation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_TEMP_FIRST;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_status.emit_req) begin
                    n_state = ST_DIV_LOAD;
                    n_op    = OP_TEMP_FIRST;
                end
            end
            ST_DIV_LOAD: begin
                n_state = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (i_status.div_done) begin
                    if (r_op == OP_HUM_SECOND) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_DIV_LOAD;
                        n_op    = t_op'(r_op + 2'd1);
                    end
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = r_op;
        o_in_stall      = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            ST_DIV_LOAD: begin
                o_cmd.div_start = 1'b1;
            end
            ST_DIV_RUN: begin
                o_cmd.store_q = i_status.div_done;
            end
            ST_OUT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

/* hdl/hdsa_div.sv */
// ----------------------------------------------------------------------------
// hdsa_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hdsa_div #(
    parameter int DVD_W = 28,
    parameter int DVS_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   diff;
    logic             fits;
    logic [DVS_W-1:0] n_rem;

    // one trial subtraction
    always_comb begin
        shifted = {r_rem, r_quo[DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        fits    = shifted >= {1'b0, r_dvs};
        n_rem   = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DVD_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hdl/hdsa_dpath.sv */
// ----------------------------------------------------------------------------
// hdsa_dpath
// Window registers, per-half sums and counts, day-close snapshot, shared
// divider and output register.
// ----------------------------------------------------------------------------
module hdsa_dpath #(
    parameter int COUNT_BITS = hdsa_pkg::COUNT_BITS_DEF,
    parameter int DAY_BITS   = hdsa_pkg::DAY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hdsa_pkg::t_in_item              i_in_data,
    input  logic                            i_cfg_valid,
    input  logic [hdsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hdsa_pkg::SEC_W-1:0]      i_cfg_data,
    input  logic                            i_out_stall,
    input  hdsa_pkg::t_ctrl_cmd             i_cmd,
    output hdsa_pkg::t_dp_status            o_status,
    output logic                            o_out_valid,
    output hdsa_pkg::t_out_item             o_out_data
);
    import hdsa_pkg::*;

    localparam int TSUM_W = TEMP_W + COUNT_BITS;
    localparam int HSUM_W = HUM_W + COUNT_BITS;
    localparam int DIV_W  = TSUM_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // window registers
    logic [SEC_W-1:0] r_fs, r_fe, r_ss, r_se;

    // live accumulation state
    logic                     r_open;
    logic [DAY_BITS-1:0]      r_open_day;
    logic signed [TSUM_W-1:0] r_tsum1, r_tsum2;
    logic [HSUM_W-1:0]        r_hsum1, r_hsum2;
    logic [COUNT_BITS-1:0]    r_cnt1, r_cnt2;

    logic                     n_open;
    logic [DAY_BITS-1:0]      n_open_day;
    logic signed [TSUM_W-1:0] n_tsum1, n_tsum2;
    logic [HSUM_W-1:0]        n_hsum1, n_hsum2;
    logic [COUNT_BITS-1:0]    n_cnt1, n_cnt2;

    // snapshot of the closing day
    logic [DAY_BITS-1:0]      s_day;
    logic signed [TSUM_W-1:0] s_tsum1, s_tsum2;
    logic [HSUM_W-1:0]        s_hsum1, s_hsum2;
    logic [COUNT_BITS-1:0]    s_cnt1, s_cnt2;

    // quotients
    logic [TEMP_W-1:0] r_mt1, r_mt2;
    logic [HUM_W-1:0]  r_mh1, r_mh2;
    logic              r_neg;

    // output register
    logic      r_out_valid;
    t_out_item r_out_data;

    logic [DAY_BITS-1:0]      day_in;
    logic                     is_flush;
    logic                     close_day;
    logic                     any_samples;
    logic                     in_first;
    logic                     in_second;
    logic signed [TSUM_W-1:0] temp_ext;
    logic [HSUM_W-1:0]        hum_ext;
    logic                     emit_req;
    logic                     out_free;

    logic [DIV_W-1:0]         dvd;
    logic [COUNT_BITS-1:0]    dvs;
    logic                     dvd_neg;
    logic                     div_done;
    logic [DIV_W-1:0]         quo;
    logic [DIV_W-1:0]         quo_signed;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs <= FIRST_START_RST;
            r_fe <= FIRST_END_RST;
            r_ss <= SECOND_START_RST;
            r_se <= SECOND_END_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_FIRST_START:  r_fs <= i_cfg_data;
                REG_FIRST_END:    r_fe <= i_cfg_data;
                REG_SECOND_START: r_ss <= i_cfg_data;
                REG_SECOND_END:   r_se <= i_cfg_data;
                default:          r_fs <= r_fs;
            endcase
        end
    end

    // item decode
    always_comb begin
        day_in      = DAY_BITS'({{DAY_BITS{1'b0}}, i_in_data.day_number});
        is_flush    = i_in_data.cmd == CMD_FLUSH;
        close_day   = r_open && (day_in != r_open_day);
        any_samples = (r_cnt1 != '0) || (r_cnt2 != '0);
        emit_req    = is_flush ? (r_open && any_samples) : close_day;
        in_first    = (i_in_data.second_of_day >= r_fs) &&
                      (i_in_data.second_of_day <= r_fe);
        in_second   = !in_first && (i_in_data.second_of_day >= r_ss) &&
                      (i_in_data.second_of_day <= r_se);
        temp_ext    = {{(TSUM_W-TEMP_W){i_in_data.temperature[TEMP_W-1]}},
                       i_in_data.temperature};
        hum_ext     = {{(HSUM_W-HUM_W){1'b0}}, i_in_data.humidity};
    end

    // next accumulation state
    always_comb begin
        n_open     = r_open;
        n_open_day = r_open_day;
        n_tsum1    = r_tsum1;
        n_tsum2    = r_tsum2;
        n_hsum1    = r_hsum1;
        n_hsum2    = r_hsum2;
        n_cnt1     = r_cnt1;
        n_cnt2     = r_cnt2;
        if (i_cmd.take) begin
            if (is_flush || close_day) begin
                n_tsum1 = '0;
                n_tsum2 = '0;
                n_hsum1 = '0;
                n_hsum2 = '0;
                n_cnt1  = '0;
                n_cnt2  = '0;
            end
            if (is_flush) begin
                n_open     = 1'b0;
                n_open_day = '0;
            end else begin
                n_open     = 1'b1;
                n_open_day = day_in;
                // saturated halves ignore further samples
                if (in_first && (n_cnt1 != COUNT_MAX)) begin
                    n_tsum1 = n_tsum1 + temp_ext;
                    n_hsum1 = n_hsum1 + hum_ext;
                    n_cnt1  = n_cnt1 + 1'b1;
                end else if (in_second && (n_cnt2 != COUNT_MAX)) begin
                    n_tsum2 = n_tsum2 + temp_ext;
                    n_hsum2 = n_hsum2 + hum_ext;
                    n_cnt2  = n_cnt2 + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_open_day <= '0;
            r_tsum1    <= '0;
            r_tsum2    <= '0;
            r_hsum1    <= '0;
            r_hsum2    <= '0;
            r_cnt1     <= '0;
            r_cnt2     <= '0;
        end else begin
            r_open     <= n_open;
            r_open_day <= n_open_day;
            r_tsum1    <= n_tsum1;
            r_tsum2    <= n_tsum2;
            r_hsum1    <= n_hsum1;
            r_hsum2    <= n_hsum2;
            r_cnt1     <= n_cnt1;
            r_cnt2     <= n_cnt2;
        end
    end

    // capture the closing day before it is cleared
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && emit_req) begin
            s_day   <= r_open_day;
            s_tsum1 <= r_tsum1;
            s_tsum2 <= r_tsum2;
            s_hsum1 <= r_hsum1;
            s_hsum2 <= r_hsum2;
            s_cnt1  <= r_cnt1;
            s_cnt2  <= r_cnt2;
        end
    end

    // divider operand select, temperature as magnitude and sign
    always_comb begin
        dvd     = '0;
        dvs     = s_cnt1;
        dvd_neg = 1'b0;
        case (i_cmd.op)
            OP_TEMP_FIRST: begin
                dvd_neg = s_tsum1[TSUM_W-1];
                dvd     = dvd_neg ? DIV_W'(-s_tsum1) : DIV_W'(s_tsum1);
            end
            OP_HUM_FIRST: begin
                dvd = {{(DIV_W-HSUM_W){1'b0}}, s_hsum1};
            end
            OP_TEMP_SECOND: begin
                dvs     = s_cnt2;
                dvd_neg = s_tsum2[TSUM_W-1];
                dvd     = dvd_neg ? DIV_W'(-s_tsum2) : DIV_W'(s_tsum2);
            end
            OP_HUM_SECOND: begin
                dvs = s_cnt2;
                dvd = {{(DIV_W-HSUM_W){1'b0}}, s_hsum2};
            end
            default: begin
                dvd = '0;
            end
        endcase
    end

    hdsa_div #(
        .DVD_W (DIV_W),
        .DVS_W (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // restore the sign, truncation toward zero falls out of the magnitude
    assign quo_signed = r_neg ? (~quo + 1'b1) : quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= dvd_neg;
        end
        if (i_cmd.store_q) begin
            case (i_cmd.op)
                OP_TEMP_FIRST:  r_mt1 <= quo_signed[TEMP_W-1:0];
                OP_HUM_FIRST:   r_mh1 <= quo[HUM_W-1:0];
                OP_TEMP_SECOND: r_mt2 <= quo_signed[TEMP_W-1:0];
                OP_HUM_SECOND:  r_mh2 <= quo[HUM_W-1:0];
                default:        r_mt1 <= r_mt1;
            endcase
        end
    end

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data.record_day <=
                DAY_IN_W'({{DAY_IN_W{1'b0}}, s_day});
            r_out_data.first_present     <= s_cnt1 != '0;
            r_out_data.temp_first_mean   <= (s_cnt1 != '0) ? r_mt1 : '0;
            r_out_data.humid_first_mean  <= (s_cnt1 != '0) ? r_mh1 : '0;
            r_out_data.second_present    <= s_cnt2 != '0;
            r_out_data.temp_second_mean  <= (s_cnt2 != '0) ? r_mt2 : '0;
            r_out_data.humid_second_mean <= (s_cnt2 != '0) ? r_mh2 : '0;
        end
    end

    assign o_status.emit_req = emit_req;
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

/* hdl/half_day_sensor_averager.sv */
// ----------------------------------------------------------------------------
// half_day_sensor_averager
// Per-day, per-half-day mean of temperature and humidity samples.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data): one sample or flush per
// transfer. A sample that stays in the open day needs no divisions, so such
// samples stream at one per cycle outside a day close. A sample of a new day,
// or a flush of a day holding samples, closes the day: the four means are
// worked out one after another by a single bit-serial divider, and the
// record is loaded into the output register; o_in_stall stays high from
// the transfer until that load.
// Output channel (o_out_valid / i_out_stall / o_out_data): one day record per
// transfer, held in an output register. While the receiver stalls, the record
// holds and sample intake goes on; a further day close still runs its
// divisions, then keeps o_in_stall high until the register is free.
// Configuration (i_cfg_valid / o_cfg_ready): window bounds, ready always high;
// the user must write them only while the block is idle (not enforced).
// Reset: windows return to their defaults, no day is open, sums and counts
// are zero and the output register is empty.
// ----------------------------------------------------------------------------
module half_day_sensor_averager #(
    parameter int COUNT_BITS = hdsa_pkg::COUNT_BITS_DEF,
    parameter int DAY_BITS   = hdsa_pkg::DAY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  hdsa_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output hdsa_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hdsa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hdsa_pkg::SEC_W-1:0]      i_cfg_data
);
    import hdsa_pkg::*;

    t_ctrl_cmd  ctrl_cmd;
    t_dp_status dp_status;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    hdsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd)
    );

    hdsa_dpath #(
        .COUNT_BITS (COUNT_BITS),
        .DAY_BITS   (DAY_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/hdsa_chk.sv */
// ----------------------------------------------------------------------------
// hdsa_chk
// Port-level checks of the half-day sensor averager.
// ----------------------------------------------------------------------------
module hdsa_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_in_stall,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  hdsa_pkg::t_out_item             o_out_data
);
    import hdsa_pkg::*;

    // a stalled record holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("record changed while stalled");

    // a new record only appears after a day close held the input
    a_out_after_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("record without a day close");

    // an absent first half reports zero means
    a_first_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.first_present |->
            o_out_data.temp_first_mean == '0 && o_out_data.humid_first_mean == '0)
        else $error("absent first half with nonzero mean");

    // an absent second half reports zero means
    a_second_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.second_present |->
            o_out_data.temp_second_mean == '0 && o_out_data.humid_second_mean == '0)
        else $error("absent second half with nonzero mean");

endmodule

bind half_day_sensor_averager hdsa_chk u_hdsa_chk (.*);
